// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out under SYNTHESIS
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== hdl/klt_pkg.sv =====
// ----------------------------------------------------------------------------
// klt_pkg
// types, constants and helpers of the keyed level table
// ----------------------------------------------------------------------------
`default_nettype none
package klt_pkg;

  localparam int DEPTH   = 1024;
  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int COUNT_W = 11;

  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] cnt_t;

  localparam cnt_t CNT_ONE   = CW'(1);
  localparam cnt_t CNT_DEPTH = CW'(DEPTH);

  localparam logic [2:0] OP_ADD        = 3'd0;
  localparam logic [2:0] OP_DELETE     = 3'd1;
  localparam logic [2:0] OP_FIND       = 3'd2;
  localparam logic [2:0] OP_CAN_ADD    = 3'd3;
  localparam logic [2:0] OP_SET_ACTIVE = 3'd4;
  localparam logic [2:0] OP_CLEAR      = 3'd5;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] recipe_id;
    logic [15:0] level;
    logic        active_flag;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic               found_active;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] level;
    logic        active;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic idle;
    cnt_t count;
  } ctl_stat_t;

  function automatic logic [COUNT_W-1:0] cnt_to_rsp(input cnt_t c);
    return COUNT_W'(c);
  endfunction

  function automatic addr_t cnt_to_addr(input cnt_t c);
    return c[AW-1:0];
  endfunction

  function automatic logic is_scan_op(input logic [2:0] op);
    return (op == OP_ADD) || (op == OP_DELETE) || (op == OP_FIND) ||
           (op == OP_CAN_ADD) || (op == OP_SET_ACTIVE);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/keyed_level_table_top.sv =====
// ----------------------------------------------------------------------------
// keyed_level_table_top
// keyed level table: add, delete, find, can_add, set_active and clear
//
//   channel  ports                          carries
//   in       in_valid, in_ready, in_req     one request (op, id, level, flag)
//   out      out_valid, out_ready, out_rsp  one result per request
//
// the id compare walks the entry ram one slot a cycle over the valid entries
// and stops at the first hit
// clear and unused op codes skip the walk; a delete whose hit also matches
// the level goes through ST_LAST and ST_MOVE to read the last entry and move it into the freed slot
// rst_n empties the table at once; entries are not cleared
// the result register lets the next request in while a result waits
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module keyed_level_table_top (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire klt_pkg::req_t   in_req,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output klt_pkg::rsp_t        out_rsp
);

  klt_pkg::ctl_stat_t stat;
  logic               res_valid;
  logic               res_ready;
  klt_pkg::rsp_t      res;
  logic               wr_en;
  klt_pkg::addr_t     wr_addr;
  klt_pkg::entry_t    wr_data;
  klt_pkg::addr_t     rd_addr;
  klt_pkg::entry_t    rd_data;
  logic               out_valid_r, out_valid_nxt;
  klt_pkg::rsp_t      out_rsp_r, out_rsp_nxt;

  klt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req       (in_req),
    .stat      (stat),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  klt_ram #(
    .WIDTH (klt_pkg::ENTRY_W),
    .DEPTH (klt_pkg::DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready  = stat.idle;
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_rsp_nxt   = out_rsp_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_rsp_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  `ASSERT_CLK(a_count_range, clk, rst_n, stat.count <= klt_pkg::CNT_DEPTH, "entry count above depth")
  `ASSERT_CLK(a_busy_after_request, clk, rst_n, in_valid && in_ready |=> !in_ready, "ready right after request")
  `ASSERT_CLK(a_result_held, clk, rst_n, res_valid && !res_ready |=> res_valid && $stable(res), "pending result lost")
  `ASSERT_NORST(a_reset_empty, clk, !rst_n |=> !out_valid && stat.count == '0, "not empty after reset")

endmodule
`default_nettype wire

// ===== hdl/klt_ram.sv =====
// ----------------------------------------------------------------------------
// klt_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module klt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== hdl/klt_ctrl.sv =====
// ----------------------------------------------------------------------------
// klt_ctrl
// sequencer with shared id compare: scans slots, then executes the request and may update the table
// ----------------------------------------------------------------------------
`default_nettype none
module klt_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                req_valid,
  input  wire klt_pkg::req_t       req,
  output klt_pkg::ctl_stat_t       stat,
  input  wire logic                res_ready,
  output logic                     res_valid,
  output klt_pkg::rsp_t            res,
  output logic                     wr_en,
  output klt_pkg::addr_t           wr_addr,
  output klt_pkg::entry_t          wr_data,
  output klt_pkg::addr_t           rd_addr,
  input  wire klt_pkg::entry_t     rd_data
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SCAN = 6'b000010,
    ST_EXEC = 6'b000100,
    ST_LAST = 6'b001000,
    ST_MOVE = 6'b010000,
    ST_RESP = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  klt_pkg::cnt_t     cnt_r, cnt_nxt;
  klt_pkg::req_t     req_r, req_nxt;
  klt_pkg::cnt_t     idx_r, idx_nxt;
  logic              chk_r, chk_nxt;
  klt_pkg::addr_t    chk_idx_r, chk_idx_nxt;
  logic              hit_r, hit_nxt;
  klt_pkg::addr_t    slot_r, slot_nxt;
  klt_pkg::entry_t   hit_ent_r, hit_ent_nxt;
  logic              ok_r, ok_nxt;
  logic              fact_r, fact_nxt;
  logic              more;
  logic              exact;
  klt_pkg::cnt_t     last_cnt;
  klt_pkg::entry_t   new_ent;

  assign more     = idx_r < cnt_r;
  assign exact    = hit_r && (hit_ent_r.level == req_r.level);
  assign last_cnt = cnt_r - klt_pkg::CNT_ONE;
  assign new_ent  = '{id: req_r.recipe_id, level: req_r.level, active: req_r.active_flag};

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    req_nxt     = req_r;
    idx_nxt     = idx_r;
    chk_nxt     = chk_r;
    chk_idx_nxt = chk_idx_r;
    hit_nxt     = hit_r;
    slot_nxt    = slot_r;
    hit_ent_nxt = hit_ent_r;
    ok_nxt      = ok_r;
    fact_nxt    = fact_r;
    wr_en       = 1'b0;
    wr_addr     = slot_r;
    wr_data     = new_ent;
    rd_addr     = klt_pkg::cnt_to_addr(idx_r);
    res_valid   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          req_nxt = req;
          idx_nxt = '0;
          chk_nxt = 1'b0;
          hit_nxt = 1'b0;
          if (klt_pkg::is_scan_op(req.op) && (cnt_r != '0)) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_EXEC;
          end
        end
      end
      ST_SCAN: begin
        chk_nxt = more;
        if (more) begin
          idx_nxt     = idx_r + klt_pkg::CNT_ONE;
          chk_idx_nxt = klt_pkg::cnt_to_addr(idx_r);
        end
        if (chk_r && (rd_data.id == req_r.recipe_id)) begin
          hit_nxt     = 1'b1;
          slot_nxt    = chk_idx_r;
          hit_ent_nxt = rd_data;
          state_nxt   = ST_EXEC;
        end else if (!chk_r && !more) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ok_nxt    = 1'b0;
        fact_nxt  = 1'b0;
        state_nxt = ST_RESP;
        case (req_r.op)
          klt_pkg::OP_ADD: begin
            if (hit_r) begin
              ok_nxt = 1'b1;
              if (hit_ent_r.level < req_r.level) begin
                wr_en = 1'b1;
              end
            end else if (cnt_r < klt_pkg::CNT_DEPTH) begin
              wr_en   = 1'b1;
              wr_addr = klt_pkg::cnt_to_addr(cnt_r);
              cnt_nxt = cnt_r + klt_pkg::CNT_ONE;
              ok_nxt  = 1'b1;
            end
          end
          klt_pkg::OP_DELETE: begin
            if (exact) begin
              state_nxt = ST_LAST;
            end
          end
          klt_pkg::OP_FIND: begin
            ok_nxt   = exact;
            fact_nxt = exact && hit_ent_r.active;
          end
          klt_pkg::OP_CAN_ADD: begin
            ok_nxt = !(hit_r && (hit_ent_r.level >= req_r.level));
          end
          klt_pkg::OP_SET_ACTIVE: begin
            if (exact) begin
              wr_en   = 1'b1;
              wr_data = '{id: hit_ent_r.id, level: hit_ent_r.level,
                          active: req_r.active_flag};
              ok_nxt  = 1'b1;
            end
          end
          klt_pkg::OP_CLEAR: begin
            cnt_nxt = '0;
            ok_nxt  = 1'b1;
          end
          default: begin
            ok_nxt = 1'b0;
          end
        endcase
      end
      ST_LAST: begin
        rd_addr   = klt_pkg::cnt_to_addr(last_cnt);
        state_nxt = ST_MOVE;
      end
      ST_MOVE: begin
        // last entry fills the freed slot
        wr_en     = 1'b1;
        wr_data   = rd_data;
        cnt_nxt   = last_cnt;
        ok_nxt    = 1'b1;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    idx_r     <= idx_nxt;
    chk_r     <= chk_nxt;
    chk_idx_r <= chk_idx_nxt;
    hit_r     <= hit_nxt;
    slot_r    <= slot_nxt;
    hit_ent_r <= hit_ent_nxt;
    ok_r      <= ok_nxt;
    fact_r    <= fact_nxt;
  end

  assign res  = '{ok: ok_r, found_active: fact_r,
                  entry_count: klt_pkg::cnt_to_rsp(cnt_r)};
  assign stat = '{idle: (state_r == ST_IDLE), count: cnt_r};

endmodule
`default_nettype wire
